FILE: design/ujson_pkg.sv
// Shared types, character codes and the code point encoder of the UTF-16 to
// JSON-escaped UTF-8 converter. No dependencies.
`timescale 1ns / 1ps

package ujson_pkg;

   // Beat descriptor queue between the front and back parts
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Segment positions inside a descriptor, in output order
   localparam int SEG_OPEN  = 0;
   localparam int SEG_FLUSH = 1;
   localparam int SEG_MAIN  = 2;
   localparam int SEG_CLOSE = 3;
   localparam int SEG_N     = 4;

   // Characters
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_U     = 8'h75;

   localparam logic [20:0] CP_LINE_SEP = 21'h2028;
   localparam logic [20:0] CP_PARA_SEP = 21'h2029;
   localparam logic [20:0] CP_CTRL_MAX = 21'h1F;
   localparam logic [20:0] CP_1B_MAX   = 21'h7F;
   localparam logic [20:0] CP_2B_MAX   = 21'h7FF;
   localparam logic [20:0] CP_3B_MAX   = 21'hFFFF;

   // What one accepted item asks the back part to emit
   typedef struct packed {
      logic        open_q;
      logic        flush_en;
      logic [15:0] flush_cp;
      logic        main_en;
      logic [20:0] main_cp;
      logic        close_q;
   } desc_type;

   // Bytes of one encoded code point, byte 0 first
   typedef struct packed {
      logic [5:0][7:0] bytes;
      logic [2:0]      len;
   } enc_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
   endfunction

   function automatic enc_type encode_cp(input logic [20:0] cp);
      enc_type    e;
      logic [7:0] letter;
      e.bytes = '0;
      e.len   = 3'd0;
      case (cp)
         21'h08:  letter = CH_B;
         21'h09:  letter = CH_T;
         21'h0A:  letter = CH_N;
         21'h0C:  letter = CH_F;
         21'h0D:  letter = CH_R;
         21'h22:  letter = CH_QUOTE;
         21'h2F:  letter = CH_SLASH;
         21'h5C:  letter = CH_BSL;
         default: letter = 8'h00;
      endcase
      if (letter != 8'h00) begin
         e.bytes[0] = CH_BSL;
         e.bytes[1] = letter;
         e.len      = 3'd2;
      end else if (cp <= CP_CTRL_MAX || cp == CP_LINE_SEP || cp == CP_PARA_SEP) begin
         e.bytes[0] = CH_BSL;
         e.bytes[1] = CH_U;
         e.bytes[2] = hex_digit(cp[15:12]);
         e.bytes[3] = hex_digit(cp[11:8]);
         e.bytes[4] = hex_digit(cp[7:4]);
         e.bytes[5] = hex_digit(cp[3:0]);
         e.len      = 3'd6;
      end else if (cp <= CP_1B_MAX) begin
         e.bytes[0] = cp[7:0];
         e.len      = 3'd1;
      end else if (cp <= CP_2B_MAX) begin
         e.bytes[0] = {3'b110, cp[10:6]};
         e.bytes[1] = {2'b10, cp[5:0]};
         e.len      = 3'd2;
      end else if (cp <= CP_3B_MAX) begin
         e.bytes[0] = {4'b1110, cp[15:12]};
         e.bytes[1] = {2'b10, cp[11:6]};
         e.bytes[2] = {2'b10, cp[5:0]};
         e.len      = 3'd3;
      end else begin
         e.bytes[0] = {5'b11110, cp[20:18]};
         e.bytes[1] = {2'b10, cp[17:12]};
         e.bytes[2] = {2'b10, cp[11:6]};
         e.bytes[3] = {2'b10, cp[5:0]};
         e.len      = 3'd4;
      end
      return e;
   endfunction

endpackage

FILE: design/ujson_front.sv
// Front part: accepts UTF-16 units, pairs surrogates and builds one descriptor
// per item. Depends on ujson_pkg.
`timescale 1ns / 1ps

module ujson_front
   import ujson_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] code_unit,
   input  logic        string_first,
   input  logic        string_last,
   input  logic        no_unit,
   input  logic        queue_full,
   output logic        push,
   output desc_type    desc
);

   logic [15:0] held_ff, held_in;
   logic        held_valid_ff, held_valid_in;
   logic        accept, held_v, is_low, is_high, capture;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // A new string drops a surrogate left over from an unclosed one
   assign held_v  = held_valid_ff && !string_first;
   assign is_low  = (code_unit[15:10] == 6'b110111);
   assign is_high = (code_unit[15:10] == 6'b110110);

   always_comb begin
      desc          = '0;
      desc.open_q   = string_first;
      desc.close_q  = string_last;
      desc.flush_cp = held_ff;
      capture       = 1'b0;
      held_valid_in = held_v;
      if (!no_unit) begin
         held_valid_in = 1'b0;
         if (held_v && is_low) begin
            desc.main_en = 1'b1;
            desc.main_cp = {1'b0, held_ff[9:0], code_unit[9:0]} + 21'h10000;
         end else begin
            desc.flush_en = held_v;
            if (is_high && !string_last) begin
               capture       = 1'b1;
               held_valid_in = 1'b1;
            end else begin
               desc.main_en = 1'b1;
               desc.main_cp = {5'd0, code_unit};
            end
         end
      end else if (string_last) begin
         desc.flush_en = held_v;
         held_valid_in = 1'b0;
      end
   end

   assign held_in = capture ? code_unit : held_ff;
   assign push    = accept && (desc.open_q || desc.flush_en || desc.main_en || desc.close_q);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
      end else if (accept) begin
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
      end
   end

endmodule

FILE: design/ujson_queue.sv
// Short shifting queue of descriptors between the front and back parts.
// Depends on ujson_pkg.
`timescale 1ns / 1ps

module ujson_queue
   import ujson_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type wr_desc,
   input  logic     pop,
   output desc_type head,
   output logic     head_valid,
   output logic     full
);

   desc_type          q_ff [QUEUE_DEPTH];
   desc_type          q_in [QUEUE_DEPTH];
   logic [QCNT_W-1:0] count_ff, count_in, wr_pos;

   assign head       = q_ff[0];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign wr_pos     = count_ff - QCNT_W'(pop);
   assign count_in   = count_ff + QCNT_W'(push) - QCNT_W'(pop);

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) begin
            q_in[i] = q_ff[i + 1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (push && wr_pos == QCNT_W'(i)) begin
            q_in[i] = wr_desc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule

FILE: design/ujson_back.sv
// Back part: walks the segments of the head descriptor one byte per beat and
// holds the result in an output register. Depends on ujson_pkg.
`timescale 1ns / 1ps

module ujson_back
   import ujson_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  desc_type   head,
   input  logic       head_valid,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] out_byte,
   output logic       run_last
);

   logic [SEG_N-1:0] done_ff, done_in;
   logic [2:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       byte_ff;
   logic             last_ff;

   logic [SEG_N-1:0] present, remaining, cur, others;
   logic [20:0]      cp_sel;
   enc_type          enc;
   logic             is_quote, seg_end, item_end, fire;
   logic [2:0]       seg_len;
   logic [7:0]       byte_sel;

   always_comb begin
      present            = '0;
      present[SEG_OPEN]  = head.open_q;
      present[SEG_FLUSH] = head.flush_en;
      present[SEG_MAIN]  = head.main_en;
      present[SEG_CLOSE] = head.close_q;
   end

   assign remaining = present & ~done_ff;
   assign cur       = remaining & (~remaining + SEG_N'(1));
   assign others    = remaining & ~cur;

   // One encoder serves the flushed surrogate and the main code point
   assign cp_sel   = cur[SEG_FLUSH] ? {5'd0, head.flush_cp} : head.main_cp;
   assign enc      = encode_cp(cp_sel);
   assign is_quote = cur[SEG_OPEN] || cur[SEG_CLOSE];
   assign seg_len  = is_quote ? 3'd1 : enc.len;
   assign byte_sel = is_quote ? CH_QUOTE : enc.bytes[idx_ff];
   assign seg_end  = (idx_ff == seg_len - 3'd1);
   assign item_end = seg_end && (others == '0);

   assign fire = head_valid && (!rsp_valid_ff || rsp_tready);
   assign pop  = fire && item_end;

   always_comb begin
      done_in = done_ff;
      idx_in  = idx_ff;
      if (fire) begin
         if (item_end) begin
            done_in = '0;
            idx_in  = 3'd0;
         end else if (seg_end) begin
            done_in = done_ff | cur;
            idx_in  = 3'd0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= byte_sel;
         last_ff <= item_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign out_byte   = byte_ff;
   assign run_last   = last_ff;

endmodule

FILE: design/utf16_to_utf8_json_escaper_top.sv
// Top level of the UTF-16 to JSON-escaped UTF-8 converter.
// Depends on ujson_pkg, ujson_front, ujson_queue and ujson_back.
`timescale 1ns / 1ps

// Takes the UTF-16 code units of JSON strings on the req_ stream, one unit per
// beat, and returns the quoted, escaped UTF-8 text on the rsp_ stream, one byte
// per beat. A string opens with an opening quote on its first beat and ends with
// a closing quote after its last. Surrogate pairs become one four-byte sequence;
// a lone surrogate is sent as its own three-byte value, and a high surrogate is
// held back until the next unit shows whether it pairs. Control characters,
// quote, slash, backslash and U+2028/U+2029 are escaped. rsp_tlast marks the
// last byte produced by one input beat; an input beat that only holds a
// surrogate, or that carries no unit and no flag, produces no bytes at all.
// Rate: the output side moves one byte per cycle while rsp_tready is high and
// the queue holds a descriptor; an input beat makes 1 to 10 bytes. The byte
// serialiser in the back part sets the output rate. A four-entry descriptor
// queue sits between the input classifier and the serialiser, so the input
// keeps taking beats while a long escape is being sent, as long as the queue
// is not full, and the output register is refilled on the same edge at which
// its byte is taken, so an unstalled output moves one byte every cycle.

module utf16_to_utf8_json_escaper_top
   import ujson_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input unit stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   input  logic [1:0]  req_tuser,   // [0] string_first, [1] no_unit
   input  logic        req_tlast,   // string_last
   // output byte stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast    // run_last
);

   desc_type front_desc, head_desc;
   logic     front_push, queue_full, head_valid, back_pop;

   // Front: surrogate pairing and per-beat classification
   ujson_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .code_unit    (req_tdata),
      .string_first (req_tuser[0]),
      .string_last  (req_tlast),
      .no_unit      (req_tuser[1]),
      .queue_full   (queue_full),
      .push         (front_push),
      .desc         (front_desc)
   );

   // Queue: decouples the classifier from the serialiser
   ujson_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .wr_desc    (front_desc),
      .pop        (back_pop),
      .head       (head_desc),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   // Back: quote, escape and UTF-8 byte serialiser with output register
   ujson_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_desc),
      .head_valid (head_valid),
      .pop        (back_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_byte   (rsp_tdata),
      .run_last   (rsp_tlast)
   );

endmodule

FILE: design/ujson_checker.sv
// Port-level checks on the converter's output stream, bound to the top level.
// Depends on utf16_to_utf8_json_escaper_top only through the bind.
`timescale 1ns / 1ps

module ujson_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   logic rsp_beat;
   logic after_lead_ff;

   assign rsp_beat = rsp_tvalid && rsp_tready;

   // Set while the last byte sent was a UTF-8 lead byte
   always_ff @(posedge clock) begin
      if (reset) begin
         after_lead_ff <= 1'b0;
      end else if (rsp_beat) begin
         after_lead_ff <= (rsp_tdata[7:6] == 2'b11);
      end
   end

   // No output beat is offered straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A stalled output beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output beat changed");

   // A lead byte never ends the bytes of an input beat
   a_lead_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[7:6] != 2'b11)
      else $error("UTF-8 lead byte marked last");

   // A lead byte is always followed by a continuation byte
   a_lead_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && after_lead_ff |-> rsp_tdata[7:6] == 2'b10)
      else $error("UTF-8 lead byte not followed by continuation");

endmodule

bind utf16_to_utf8_json_escaper_top ujson_checker u_ujson_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
